// ----- rtl/core/lafb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and latency helpers for the look-at frame basis unit.
// No dependencies; imported by every module of the block except lafb_dly.
package lafb_pkg;

  localparam int IN_WIDTH_DEF = 32;
  localparam int OUT_FRAC_DEF = 30;
  localparam int INNER_FRAC   = 30;   // fraction bits of internal unit vectors
  localparam int OUT_W        = 32;   // result field width
  localparam int UNIT_W       = 32;   // internal unit component, signed
  localparam int MAG_W        = 30;   // block-normalised magnitude width
  localparam int SQRT_STEPS   = 32;   // one result bit per stage
  localparam int CROSS_W      = 2 * UNIT_W;
  localparam int CROSS_LAT    = 2;

  // quotient fraction bits: one more than the finest rounding needs
  function automatic int div_frac(input int out_frac);
    return ((out_frac > INNER_FRAC) ? out_frac : INNER_FRAC) + 1;
  endfunction

  // register stages of one normalisation pipe
  function automatic int norm_lat(input int out_frac);
    return 6 + SQRT_STEPS + div_frac(out_frac) + 1;
  endfunction

endpackage

// ----- rtl/core/lafb_dly.sv -----
`timescale 1ns / 1ps
// Enable-gated register delay line used to align side paths with the pipes.
// Depends on nothing outside itself.
module lafb_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_r [D];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign q_o = line_r[D-1];

endmodule

// ----- rtl/core/lafb_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input transfers, forms eye minus target and parks the
// item in a two-entry queue ahead of the compute pipe. Uses lafb_pkg.
module lafb_front #(
  parameter int IN_WIDTH = lafb_pkg::IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [IN_WIDTH-1:0] eye_i    [3],
  input  logic signed [IN_WIDTH-1:0] target_i [3],
  input  logic signed [IN_WIDTH-1:0] up_i     [3],
  input  logic                       pop_i,
  output logic                       item_valid_o,
  output logic signed [IN_WIDTH:0]   back_o   [3],
  output logic signed [IN_WIDTH-1:0] up_o     [3]
);
  import lafb_pkg::*;

  logic signed [IN_WIDTH:0]   back_q_r [2][3];
  logic signed [IN_WIDTH-1:0] up_q_r   [2][3];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_stall     = (count_r == 2'd2);
  assign push         = in_valid && !in_stall;
  assign item_valid_o = (count_r != 2'd0);
  assign pop          = pop_i && item_valid_o;

  // queue storage: back vector is the one subtraction done up front
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 3; i++) begin
        back_q_r[wr_ptr_r][i] <= (IN_WIDTH+1)'(eye_i[i]) - (IN_WIDTH+1)'(target_i[i]);
        up_q_r[wr_ptr_r][i]   <= up_i[i];
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      back_o[i] = back_q_r[rd_ptr_r][i];
      up_o[i]   = up_q_r[rd_ptr_r][i];
    end
  end

endmodule

// ----- rtl/core/lafb_cross.sv -----
`timescale 1ns / 1ps
// Two-stage cross product of two internal unit vectors.
// Uses lafb_pkg for widths.
module lafb_cross (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [lafb_pkg::UNIT_W-1:0]  a_i [3],
  input  logic signed [lafb_pkg::UNIT_W-1:0]  b_i [3],
  output logic signed [lafb_pkg::CROSS_W-1:0] c_o [3]
);
  import lafb_pkg::*;

  logic signed [CROSS_W-1:0] prod_r [6];
  logic signed [CROSS_W-1:0] c_r    [3];

  // stage 1: six products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= a_i[1] * b_i[2];
      prod_r[1] <= a_i[2] * b_i[1];
      prod_r[2] <= a_i[2] * b_i[0];
      prod_r[3] <= a_i[0] * b_i[2];
      prod_r[4] <= a_i[0] * b_i[1];
      prod_r[5] <= a_i[1] * b_i[0];
    end
  end

  // stage 2: differences
  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= prod_r[0] - prod_r[1];
      c_r[1] <= prod_r[2] - prod_r[3];
      c_r[2] <= prod_r[4] - prod_r[5];
    end
  end

  assign c_o = c_r;

endmodule

// ----- rtl/core/lafb_norm.sv -----
`timescale 1ns / 1ps
// Vector normalisation pipe: block shift, sum of squares, bit-per-stage
// square root and bit-per-stage division. Uses lafb_pkg.
module lafb_norm #(
  parameter int VW       = 33,
  parameter int OUT_FRAC = lafb_pkg::OUT_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [VW-1:0]               vec_i   [3],
  output logic signed [lafb_pkg::UNIT_W-1:0] unit_o  [3],
  output logic signed [lafb_pkg::OUT_W-1:0]  frame_o [3],
  output logic                              zero_o
);
  import lafb_pkg::*;

  localparam int F    = div_frac(OUT_FRAC);
  localparam int QW   = F + 1;
  localparam int LW   = $clog2(VW + 1);
  localparam int SW   = VW + MAG_W;
  localparam int SQW  = 2 * MAG_W;
  localparam int NW   = 2 * MAG_W + 4;
  localparam int DW   = 32;
  localparam int RW   = MAG_W + 3;
  localparam int FLN  = 4 + SQRT_STEPS + QW;   // flag line runs R1 .. last div stage

  // stage 0: magnitudes and signs
  logic [VW-1:0] mag0_r [3];
  logic [2:0]    neg0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag0_r[i] <= vec_i[i][VW-1] ? $unsigned(-vec_i[i]) : $unsigned(vec_i[i]);
        neg0_r[i] <= vec_i[i][VW-1];
      end
    end
  end

  // stage 1: leading-one position of the combined magnitudes
  logic [VW-1:0] all_c;
  logic [LW-1:0] len_c, len1_r;
  logic [VW-1:0] mag1_r [3];
  logic [3:0]    fl_r   [1:FLN];   // {zero, neg[2:0]}

  always_comb begin
    all_c = mag0_r[0] | mag0_r[1] | mag0_r[2];
    len_c = '0;
    for (int b = 0; b < VW; b++) begin
      if (all_c[b]) len_c = LW'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len1_r   <= len_c;
      mag1_r   <= mag0_r;
      fl_r[1]  <= {(all_c == '0), neg0_r};
      for (int k = 2; k <= FLN; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // stage 2: block shift so the largest magnitude sits in [2^29, 2^30)
  logic [SW-1:0]    sh_c   [3];
  logic [MAG_W-1:0] m2_r   [3];
  logic [MAG_W-1:0] m3_r   [3];
  logic [MAG_W-1:0] m4_r   [3];
  logic [SQW-1:0]   sq3_r  [3];
  logic [NW-1:0]    sum4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (int'(len1_r) > MAG_W) begin
        sh_c[i] = SW'(mag1_r[i] >> (int'(len1_r) - MAG_W));
      end else begin
        sh_c[i] = SW'(mag1_r[i]) << (MAG_W - int'(len1_r));
      end
    end
  end

  // stages 2 to 4: shift, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m2_r[i]  <= sh_c[i][MAG_W-1:0];
        m3_r[i]  <= m2_r[i];
        m4_r[i]  <= m3_r[i];
        sq3_r[i] <= SQW'(m2_r[i]) * SQW'(m2_r[i]);
      end
      sum4_r <= NW'(sq3_r[0]) + NW'(sq3_r[1]) + NW'(sq3_r[2]);
    end
  end

  // square root, one result bit per stage
  logic [NW-1:0]    sn [SQRT_STEPS+1];
  logic [NW-1:0]    sr [SQRT_STEPS+1];
  logic [MAG_W-1:0] sm [SQRT_STEPS+1][3];

  assign sn[0] = sum4_r;
  assign sr[0] = '0;
  assign sm[0] = m4_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [NW-1:0] trial, n_c, r_c;

    always_comb begin
      trial = sr[k] + BIT;
      if (sn[k] >= trial) begin
        n_c = sn[k] - trial;
        r_c = (sr[k] >> 1) + BIT;
      end else begin
        n_c = sn[k];
        r_c = sr[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sn[k+1] <= n_c;
        sr[k+1] <= r_c;
        sm[k+1] <= sm[k];
      end
    end
  end

  // restoring division, integer bit then F fraction bits
  logic [DW-1:0] dd [QW+1];
  logic [RW-1:0] dr [QW+1][3];
  logic [QW-1:0] dq [QW+1][3];

  assign dd[0] = sr[SQRT_STEPS][DW-1:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dr[0][i] = RW'(sm[SQRT_STEPS][i]);
      dq[0][i] = '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] rs [3];
    logic [RW-1:0] rn [3];
    logic [2:0]    qb;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          rs[i] = dr[j][i];
        end else begin
          rs[i] = {dr[j][i][RW-2:0], 1'b0};
        end
        qb[i] = (rs[i] >= RW'(dd[j]));
        rn[i] = qb[i] ? (rs[i] - RW'(dd[j])) : rs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[j+1] <= dd[j];
        for (int i = 0; i < 3; i++) begin
          dr[j+1][i] <= rn[i];
          dq[j+1][i] <= {dq[j][i][QW-2:0], qb[i]};
        end
      end
    end
  end

  // round half away from zero at both precisions, apply sign
  logic [QW:0]              ti_c [3];
  logic [QW:0]              to_c [3];
  logic [QW:0]              ri_c [3];
  logic [QW:0]              ro_c [3];
  logic signed [UNIT_W-1:0] unit_r  [3];
  logic signed [OUT_W-1:0]  frame_r [3];
  logic                     zero_r;
  logic [3:0]               fl_end;

  assign fl_end = fl_r[FLN];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ti_c[i] = (QW+1)'(dq[QW][i] >> (F - INNER_FRAC - 1));
      to_c[i] = (QW+1)'(dq[QW][i] >> (F - OUT_FRAC - 1));
      ri_c[i] = (ti_c[i] + 1'b1) >> 1;
      ro_c[i] = (to_c[i] + 1'b1) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= fl_end[3];
      for (int i = 0; i < 3; i++) begin
        if (fl_end[3]) begin
          unit_r[i]  <= '0;
          frame_r[i] <= '0;
        end else if (fl_end[i]) begin
          unit_r[i]  <= -$signed(UNIT_W'(ri_c[i]));
          frame_r[i] <= -$signed(OUT_W'(ro_c[i]));
        end else begin
          unit_r[i]  <= $signed(UNIT_W'(ri_c[i]));
          frame_r[i] <= $signed(OUT_W'(ro_c[i]));
        end
      end
    end
  end

  assign unit_o  = unit_r;
  assign frame_o = frame_r;
  assign zero_o  = zero_r;

endmodule

// ----- rtl/core/look_at_frame_basis_unit.sv -----
`timescale 1ns / 1ps
// Look-at frame basis: eye, target and up in Q16.16 to three unit axes.
// Each item runs through three chained normalisation pipes (32 square-root
// stages, F+1 division stages each) joined by two cross products.
// Throughput: one item per cycle; the pipe holds only while a result waits under out_stall.
// Reset clears the input queue and the pipeline valid bits; data is not reset.
module look_at_frame_basis_unit #(
  parameter int IN_WIDTH      = lafb_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = lafb_pkg::OUT_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [IN_WIDTH-1:0]        in_eye_x,
  input  logic signed [IN_WIDTH-1:0]        in_eye_y,
  input  logic signed [IN_WIDTH-1:0]        in_eye_z,
  input  logic signed [IN_WIDTH-1:0]        in_target_x,
  input  logic signed [IN_WIDTH-1:0]        in_target_y,
  input  logic signed [IN_WIDTH-1:0]        in_target_z,
  input  logic signed [IN_WIDTH-1:0]        in_up_x,
  input  logic signed [IN_WIDTH-1:0]        in_up_y,
  input  logic signed [IN_WIDTH-1:0]        in_up_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lafb_pkg::OUT_W-1:0] out_right_x,
  output logic signed [lafb_pkg::OUT_W-1:0] out_right_y,
  output logic signed [lafb_pkg::OUT_W-1:0] out_right_z,
  output logic signed [lafb_pkg::OUT_W-1:0] out_upaxis_x,
  output logic signed [lafb_pkg::OUT_W-1:0] out_upaxis_y,
  output logic signed [lafb_pkg::OUT_W-1:0] out_upaxis_z,
  output logic signed [lafb_pkg::OUT_W-1:0] out_back_x,
  output logic signed [lafb_pkg::OUT_W-1:0] out_back_y,
  output logic signed [lafb_pkg::OUT_W-1:0] out_back_z,
  output logic                              out_degenerate
);
  import lafb_pkg::*;

  localparam int NL  = norm_lat(OUT_FRAC_BITS);
  localparam int SEG = NL + CROSS_LAT;
  localparam int TOT = 3 * NL + 2 * CROSS_LAT;

  logic                       adv;
  logic                       item_valid;
  logic signed [IN_WIDTH-1:0] eye [3], target [3], upv [3];
  logic signed [IN_WIDTH:0]   back_v [3];
  logic signed [IN_WIDTH-1:0] up_v   [3];
  logic                       vld_r [1:TOT];

  assign eye    = '{in_eye_x, in_eye_y, in_eye_z};
  assign target = '{in_target_x, in_target_y, in_target_z};
  assign upv    = '{in_up_x, in_up_y, in_up_z};

  // the compute pipe moves whenever the result register is free or taken
  assign out_valid = vld_r[TOT];
  assign adv       = !out_valid || !out_stall;

  lafb_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .eye_i        (eye),
    .target_i     (target),
    .up_i         (upv),
    .pop_i        (adv),
    .item_valid_o (item_valid),
    .back_o       (back_v),
    .up_o         (up_v)
  );

  // valid bits alongside the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= TOT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= item_valid;
      for (int k = 2; k <= TOT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // back axis and normalised up
  logic signed [UNIT_W-1:0] zin [3], upn [3], xin [3], yin [3];
  logic signed [OUT_W-1:0]  zo  [3], upo [3], xo  [3], yo  [3];
  logic                     zero_b, zero_u, zero_x, zero_y;

  lafb_norm #(.VW(IN_WIDTH + 1), .OUT_FRAC(OUT_FRAC_BITS)) u_norm_back (
    .clk(clk), .en(adv), .vec_i(back_v), .unit_o(zin), .frame_o(zo), .zero_o(zero_b)
  );

  lafb_norm #(.VW(IN_WIDTH), .OUT_FRAC(OUT_FRAC_BITS)) u_norm_up (
    .clk(clk), .en(adv), .vec_i(up_v), .unit_o(upn), .frame_o(upo), .zero_o(zero_u)
  );

  // right axis = up x back
  logic signed [CROSS_W-1:0] xr [3], yr [3];

  lafb_cross u_cross_x (.clk(clk), .en(adv), .a_i(upn), .b_i(zin), .c_o(xr));

  lafb_norm #(.VW(CROSS_W), .OUT_FRAC(OUT_FRAC_BITS)) u_norm_x (
    .clk(clk), .en(adv), .vec_i(xr), .unit_o(xin), .frame_o(xo), .zero_o(zero_x)
  );

  // back axis delayed to meet the right axis
  logic [3*UNIT_W-1:0] zin_q;
  logic signed [UNIT_W-1:0] zin_d [3];

  lafb_dly #(.W(3 * UNIT_W), .D(SEG)) u_dly_zin (
    .clk(clk), .en(adv), .d_i({zin[0], zin[1], zin[2]}), .q_o(zin_q)
  );
  assign zin_d = '{$signed(zin_q[3*UNIT_W-1:2*UNIT_W]),
                   $signed(zin_q[2*UNIT_W-1:UNIT_W]),
                   $signed(zin_q[UNIT_W-1:0])};

  // up axis = back x right
  lafb_cross u_cross_y (.clk(clk), .en(adv), .a_i(zin_d), .b_i(xin), .c_o(yr));

  lafb_norm #(.VW(CROSS_W), .OUT_FRAC(OUT_FRAC_BITS)) u_norm_y (
    .clk(clk), .en(adv), .vec_i(yr), .unit_o(yin), .frame_o(yo), .zero_o(zero_y)
  );

  // result alignment for the back and right axes and the degenerate flag
  logic [3*OUT_W-1:0] zo_q, xo_q;
  logic               dg1_q, dg2_q;

  lafb_dly #(.W(3 * OUT_W), .D(2 * SEG)) u_dly_zo (
    .clk(clk), .en(adv), .d_i({zo[0], zo[1], zo[2]}), .q_o(zo_q)
  );
  lafb_dly #(.W(3 * OUT_W), .D(SEG)) u_dly_xo (
    .clk(clk), .en(adv), .d_i({xo[0], xo[1], xo[2]}), .q_o(xo_q)
  );
  lafb_dly #(.W(1), .D(SEG)) u_dly_dg1 (
    .clk(clk), .en(adv), .d_i(zero_b || zero_u), .q_o(dg1_q)
  );
  lafb_dly #(.W(1), .D(SEG)) u_dly_dg2 (
    .clk(clk), .en(adv), .d_i(dg1_q || zero_x), .q_o(dg2_q)
  );

  assign out_right_x    = $signed(xo_q[3*OUT_W-1:2*OUT_W]);
  assign out_right_y    = $signed(xo_q[2*OUT_W-1:OUT_W]);
  assign out_right_z    = $signed(xo_q[OUT_W-1:0]);
  assign out_upaxis_x   = yo[0];
  assign out_upaxis_y   = yo[1];
  assign out_upaxis_z   = yo[2];
  assign out_back_x     = $signed(zo_q[3*OUT_W-1:2*OUT_W]);
  assign out_back_y     = $signed(zo_q[2*OUT_W-1:OUT_W]);
  assign out_back_z     = $signed(zo_q[OUT_W-1:0]);
  assign out_degenerate = dg2_q || zero_y;

  // a full queue drains whenever the pipe is free to move
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input queue stayed full while the pipe advanced");

  // a degenerate frame never carries a right axis
  a_degen_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_right_x == 0 && out_right_y == 0 && out_right_z == 0))
    else $error("degenerate result with non-zero right axis");

  // a sound frame has a non-zero back axis
  a_back_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (OUT_FRAC_BITS > INNER_FRAC || out_back_x != 0 || out_back_y != 0 ||
       out_back_z != 0))
    else $error("non-degenerate result with zero back axis");

endmodule
